[sv/arc_pkg.sv]
// ----------------------------------------------------------------------------
// arc_pkg
// Shared types and constants for the address range table checker.
// ----------------------------------------------------------------------------
package arc_pkg;

  localparam int unsigned MAX_RANGES_DEF = 64;
  localparam int unsigned ADDR_W  = 52;
  localparam int unsigned LEN_W   = 52;
  localparam int unsigned QEND_W  = 53;
  localparam int unsigned TOP_W   = 54;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_BUILD = 2'd2,
    OP_CHECK = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SORT  = 5'b00010,
    ST_WAVE  = 5'b00100,
    ST_PACK  = 5'b01000,
    ST_CHECK = 5'b10000
  } state_e;

  typedef enum logic [2:0] {
    CM_HOLD   = 3'd0,
    CM_LOAD   = 3'd1,
    CM_SORT   = 3'd2,
    CM_WAVE   = 3'd3,
    CM_COMMIT = 3'd4,
    CM_PACK   = 3'd5,
    CM_ROTATE = 3'd6
  } cell_mode_e;

  // one table entry as held in a cell: base, end address (base plus length) and dead flag
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [TOP_W-1:0]  top_addr;
    logic              dead;
  } cell_t;

  typedef struct packed {
    cell_mode_e mode;
    logic       parity;
  } cell_ctrl_t;

endpackage

[sv/arc_cell.sv]
// ----------------------------------------------------------------------------
// arc_cell
// One table entry: odd-even exchange with neighbors, prefix-max merge wave,
// group-end back wave, leader count chain and ring rotation for checks.
// ----------------------------------------------------------------------------
module arc_cell #(
  parameter int unsigned NumCells = arc_pkg::MAX_RANGES_DEF,
  parameter int unsigned Index    = 0,
  parameter int unsigned CntW     = 7
) (
  input  logic                            clk_i,
  input  arc_pkg::cell_ctrl_t             ctrl_i,
  input  logic [CntW-1:0]                 cnt_i,
  input  logic [arc_pkg::ADDR_W-1:0]      ld_base_i,
  input  logic [arc_pkg::TOP_W-1:0]       ld_top_i,
  input  arc_pkg::cell_t                  left_i,
  input  arc_pkg::cell_t                  right_i,
  input  logic [arc_pkg::TOP_W-1:0]       left_pmax_i,
  input  logic                            right_lead_i,
  input  logic [arc_pkg::TOP_W-1:0]       right_gend_i,
  input  logic [CntW-1:0]                 left_lnum_i,
  output arc_pkg::cell_t                  cell_o,
  output logic [arc_pkg::TOP_W-1:0]       pmax_o,
  output logic                            lead_o,
  output logic [arc_pkg::TOP_W-1:0]       gend_o,
  output logic [CntW-1:0]                 lnum_o
);

  localparam bit First = (Index == 0);
  localparam bit Last  = (Index + 1 == NumCells);
  localparam bit Odd   = (Index % 2 == 1);
  localparam logic [CntW:0] IdxW    = (CntW+1)'(Index);
  localparam logic [CntW:0] IdxNext = (CntW+1)'(Index + 1);
  localparam logic [CntW:0] AllW    = (CntW+1)'(NumCells);

  arc_pkg::cell_t                cell_q;
  logic [arc_pkg::TOP_W-1:0]     pmax_q, pmax_d;
  logic [arc_pkg::TOP_W-1:0]     gend_q, gend_d;
  logic [CntW-1:0]               lnum_q, lnum_d;
  logic [CntW:0]                 cnt_ext, lim;
  logic                          live, lead, is_lower, pair_ok, gt, last_in_group;
  arc_pkg::cell_t                lo, hi, partner;

  // liveness and group leader
  assign cnt_ext = {1'b0, cnt_i};
  assign live    = IdxW < cnt_ext;
  assign lead    = live && (First || ({2'b00, cell_q.base} > left_pmax_i));

  // odd-even exchange with the partner cell
  assign is_lower = (ctrl_i.parity == Odd);
  assign lim      = (ctrl_i.mode == arc_pkg::CM_SORT) ? cnt_ext : AllW;
  assign pair_ok  = is_lower ? (IdxNext < lim) : (!First && (IdxW < lim));
  assign partner  = is_lower ? right_i : left_i;
  assign lo       = is_lower ? cell_q : left_i;
  assign hi       = is_lower ? right_i : cell_q;
  assign gt       = (ctrl_i.mode == arc_pkg::CM_PACK) ?
                    ({lo.dead, lo.base} > {hi.dead, hi.base}) : (lo.base > hi.base);

  // merge waves
  assign pmax_d = (First || (cell_q.top_addr > left_pmax_i)) ? cell_q.top_addr : left_pmax_i;
  assign last_in_group = (IdxNext == cnt_ext) || (!Last && right_lead_i);
  assign gend_d = last_in_group ? pmax_q : right_gend_i;
  assign lnum_d = left_lnum_i + CntW'(lead);

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.mode) inside
      arc_pkg::CM_LOAD: begin
        if (IdxW == cnt_ext) begin
          cell_q.base     <= ld_base_i;
          cell_q.top_addr <= ld_top_i;
        end
      end
      arc_pkg::CM_SORT, arc_pkg::CM_PACK: begin
        if (pair_ok && gt) begin
          cell_q <= partner;
        end
      end
      arc_pkg::CM_ROTATE: begin
        cell_q <= right_i;
      end
      arc_pkg::CM_WAVE: begin
        pmax_q <= pmax_d;
        gend_q <= gend_d;
        lnum_q <= lnum_d;
      end
      arc_pkg::CM_COMMIT: begin
        pmax_q          <= pmax_d;
        gend_q          <= gend_d;
        lnum_q          <= lnum_d;
        cell_q.top_addr <= gend_q;
        cell_q.dead     <= !lead;
      end
      default: begin
      end
    endcase
  end

  assign cell_o = cell_q;
  assign pmax_o = pmax_q;
  assign lead_o = lead;
  assign gend_o = gend_q;
  assign lnum_o = lnum_q;

endmodule

[sv/address_range_table_checker.sv]
// ----------------------------------------------------------------------------
// address_range_table_checker
// Table of allowed address ranges held in a row of cells; sort, merge, check.
// ----------------------------------------------------------------------------
// clear and add: result in the cycle after the transaction, next one accepted then
// build: result after the sort, the merge waves and the compaction, in that order
// check: result after the table rotates once past the compare at cell 0
// one result per transaction, receiver cannot stall; busy_o high while working
// reset clears counts and control; table contents are undefined until added
module address_range_table_checker #(
  parameter int unsigned MAX_RANGES = arc_pkg::MAX_RANGES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [1:0]                      operation_i,
  input  logic [arc_pkg::ADDR_W-1:0]      start_address_i,
  input  logic [arc_pkg::LEN_W-1:0]       span_length_i,
  output logic                            result_valid_o,
  output logic                            inside_res_o,
  output logic [arc_pkg::COUNT_W-1:0]     entry_count_o,
  output logic                            overflow_o
);

  localparam int unsigned CntW  = $clog2(MAX_RANGES + 1);
  localparam int unsigned StepW = $clog2(2 * MAX_RANGES + 2);
  localparam int unsigned OutW  = arc_pkg::COUNT_W;
  localparam logic [StepW-1:0] RowLast  = StepW'(MAX_RANGES - 1);
  localparam logic [StepW-1:0] WaveLast = StepW'(2 * MAX_RANGES + 1);
  localparam logic [CntW-1:0]  Full     = CntW'(MAX_RANGES);

  arc_pkg::state_e              state_q, state_d;
  logic [StepW-1:0]             step_q, step_d;
  logic [CntW-1:0]              cnt_q, cnt_d, mcnt_q, mcnt_d;
  logic                         hit_q, hit_d;
  logic [arc_pkg::ADDR_W-1:0]   qstart_q, qstart_d;
  logic [arc_pkg::QEND_W-1:0]   qend_q, qend_d, in_end;
  logic                         res_valid_q, res_valid_d, inside_q, inside_d, ovf_q, ovf_d;
  logic [OutW-1:0]              count_q, count_d;
  logic                         accept, cur_hit;
  arc_pkg::op_e                 op;
  arc_pkg::cell_ctrl_t          ctrl;

  arc_pkg::cell_t               cells [MAX_RANGES];
  logic [arc_pkg::TOP_W-1:0]    pmax [MAX_RANGES];
  logic [arc_pkg::TOP_W-1:0]    gend [MAX_RANGES];
  logic                         lead [MAX_RANGES];
  logic [CntW-1:0]              lnum [MAX_RANGES];

  assign accept = start_i && (state_q == arc_pkg::ST_IDLE);
  assign op     = arc_pkg::op_e'(operation_i);
  assign in_end = {1'b0, start_address_i} + {1'b0, span_length_i};

  // compare at the head of the rotating table
  assign cur_hit = (step_q < StepW'(mcnt_q)) && (qstart_q >= cells[0].base) &&
                   ({1'b0, qend_q} <= cells[0].top_addr);

  // cell command
  always_comb begin
    ctrl.parity = step_q[0];
    ctrl.mode   = arc_pkg::CM_HOLD;
    unique case (state_q)
      arc_pkg::ST_IDLE: begin
        if (accept && (op == arc_pkg::OP_ADD) && (cnt_q != Full)) begin
          ctrl.mode = arc_pkg::CM_LOAD;
        end
      end
      arc_pkg::ST_SORT:  ctrl.mode = arc_pkg::CM_SORT;
      arc_pkg::ST_WAVE:  ctrl.mode = (step_q == WaveLast) ? arc_pkg::CM_COMMIT
                                                           : arc_pkg::CM_WAVE;
      arc_pkg::ST_PACK:  ctrl.mode = arc_pkg::CM_PACK;
      arc_pkg::ST_CHECK: ctrl.mode = arc_pkg::CM_ROTATE;
      default:           ctrl.mode = arc_pkg::CM_HOLD;
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q + StepW'(1);
    cnt_d       = cnt_q;
    mcnt_d      = mcnt_q;
    hit_d       = hit_q;
    qstart_d    = qstart_q;
    qend_d      = qend_q;
    res_valid_d = 1'b0;
    inside_d    = 1'b0;
    ovf_d       = 1'b0;
    count_d     = count_q;
    unique case (state_q)
      arc_pkg::ST_IDLE: begin
        step_d = '0;
        if (accept) begin
          unique case (op)
            arc_pkg::OP_CLEAR: begin
              cnt_d       = '0;
              mcnt_d      = '0;
              res_valid_d = 1'b1;
              count_d     = '0;
            end
            arc_pkg::OP_ADD: begin
              res_valid_d = 1'b1;
              if (cnt_q == Full) begin
                ovf_d   = 1'b1;
                count_d = OutW'(cnt_q);
              end else begin
                cnt_d   = cnt_q + CntW'(1);
                mcnt_d  = '0;
                count_d = OutW'(cnt_q + CntW'(1));
              end
            end
            arc_pkg::OP_BUILD: begin
              state_d = arc_pkg::ST_SORT;
            end
            arc_pkg::OP_CHECK: begin
              state_d  = arc_pkg::ST_CHECK;
              hit_d    = 1'b0;
              qstart_d = start_address_i;
              qend_d   = in_end;
            end
            default: begin
            end
          endcase
        end
      end
      arc_pkg::ST_SORT: begin
        if (step_q == RowLast) begin
          state_d = arc_pkg::ST_WAVE;
          step_d  = '0;
        end
      end
      arc_pkg::ST_WAVE: begin
        if (step_q == WaveLast) begin
          state_d = arc_pkg::ST_PACK;
          step_d  = '0;
          cnt_d   = lnum[MAX_RANGES-1];
        end
      end
      arc_pkg::ST_PACK: begin
        if (step_q == RowLast) begin
          state_d     = arc_pkg::ST_IDLE;
          mcnt_d      = cnt_q;
          res_valid_d = 1'b1;
          count_d     = OutW'(cnt_q);
        end
      end
      arc_pkg::ST_CHECK: begin
        hit_d = hit_q || cur_hit;
        if (step_q == RowLast) begin
          state_d     = arc_pkg::ST_IDLE;
          res_valid_d = 1'b1;
          inside_d    = hit_q || cur_hit;
          count_d     = OutW'(cnt_q);
        end
      end
      default: state_d = arc_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= arc_pkg::ST_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      mcnt_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      mcnt_q      <= mcnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hit_q    <= hit_d;
    qstart_q <= qstart_d;
    qend_q   <= qend_d;
    inside_q <= inside_d;
    ovf_q    <= ovf_d;
    count_q  <= count_d;
  end

  // row of cells, ring closed from cell 0 back to the last one
  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    arc_pkg::cell_t            left_c;
    logic [arc_pkg::TOP_W-1:0] left_pmax;
    logic [CntW-1:0]           left_lnum;
    localparam int unsigned Rgt = (i + 1) % MAX_RANGES;
    if (i == 0) begin : g_first
      assign left_c    = cells[MAX_RANGES-1];
      assign left_pmax = '0;
      assign left_lnum = '0;
    end else begin : g_rest
      assign left_c    = cells[i-1];
      assign left_pmax = pmax[i-1];
      assign left_lnum = lnum[i-1];
    end
    arc_cell #(
      .NumCells (MAX_RANGES),
      .Index    (i),
      .CntW     (CntW)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .cnt_i        (cnt_q),
      .ld_base_i    (start_address_i),
      .ld_top_i     ({1'b0, in_end}),
      .left_i       (left_c),
      .right_i      (cells[Rgt]),
      .left_pmax_i  (left_pmax),
      .right_lead_i (lead[Rgt]),
      .right_gend_i (gend[Rgt]),
      .left_lnum_i  (left_lnum),
      .cell_o       (cells[i]),
      .pmax_o       (pmax[i]),
      .lead_o       (lead[i]),
      .gend_o       (gend[i]),
      .lnum_o       (lnum[i])
    );
  end

  assign busy_o         = (state_q != arc_pkg::ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign inside_res_o   = inside_q;
  assign entry_count_o  = count_q;
  assign overflow_o     = ovf_q;

`ifndef SYNTH
  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o) else $error("result while busy");
  a_merged_le_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mcnt_q <= cnt_q) else $error("merged count above loaded count");
  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && overflow_o) |-> (cnt_q == Full)) else $error("overflow not full");
  a_inside_built: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && inside_res_o) |-> (mcnt_q != '0)) else $error("hit on unbuilt table");
`endif

endmodule

[sim/address_range_table_checker_tb.sv]
// ----------------------------------------------------------------------------
// address_range_table_checker_tb
// Drives clear, add, build and check transactions into the range table and
// compares every result against a behavioral table kept in the bench.
// ----------------------------------------------------------------------------
module address_range_table_checker_tb;

  localparam int unsigned NRANGE = arc_pkg::MAX_RANGES_DEF;
  localparam int unsigned RAND_ITEMS = 460;
  localparam int unsigned ADDR_W  = arc_pkg::ADDR_W;
  localparam int unsigned LEN_W   = arc_pkg::LEN_W;
  localparam int unsigned QEND_W  = arc_pkg::QEND_W;
  localparam int unsigned TOP_W   = arc_pkg::TOP_W;
  localparam int unsigned COUNT_W = arc_pkg::COUNT_W;

  typedef struct packed {
    logic              hit;
    logic [COUNT_W-1:0] count;
    logic              ovf;
  } verdict_t;

  typedef struct {
    arc_pkg::op_e      op;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic              known;
    verdict_t          res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [1:0] operation_i = arc_pkg::OP_CLEAR;
  logic [ADDR_W-1:0] start_address_i = '0;
  logic [LEN_W-1:0] span_length_i = '0;
  logic busy_o, result_valid_o, inside_res_o, overflow_o;
  logic [COUNT_W-1:0] entry_count_o;

  // behavioral copy of the table
  logic [ADDR_W-1:0] tbl_base [NRANGE];
  logic [QEND_W-1:0] tbl_len [NRANGE];
  int unsigned tbl_loaded;
  int unsigned tbl_merged;

  verdict_t expected_q [$];
  int unsigned fail_count = 0;
  bit quiet_tail = 1'b0;

  address_range_table_checker u_top (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("address_range_table_checker test failed");
    $finish;
  end

  // sort by base then fold overlapping or touching ranges
  function automatic void build_table();
    logic [ADDR_W-1:0] b;
    logic [QEND_W-1:0] l;
    logic [TOP_W-1:0] e, e2;
    int unsigned j, rd, wr, nx;
    for (int unsigned i = 1; i < tbl_loaded; i++) begin
      b = tbl_base[i];
      l = tbl_len[i];
      j = i;
      while (j > 0 && tbl_base[j-1] > b) begin
        tbl_base[j] = tbl_base[j-1];
        tbl_len[j] = tbl_len[j-1];
        j--;
      end
      tbl_base[j] = b;
      tbl_len[j] = l;
    end
    rd = 0;
    wr = 0;
    while (rd < tbl_loaded) begin
      b = tbl_base[rd];
      e = TOP_W'(b) + TOP_W'(tbl_len[rd]);
      nx = rd + 1;
      while (nx < tbl_loaded && e >= TOP_W'(tbl_base[nx])) begin
        e2 = TOP_W'(tbl_base[nx]) + TOP_W'(tbl_len[nx]);
        if (e2 > e) e = e2;
        nx++;
      end
      tbl_base[wr] = b;
      tbl_len[wr] = QEND_W'(e - TOP_W'(b));
      wr++;
      rd = nx;
    end
    tbl_loaded = wr;
    tbl_merged = wr;
  endfunction

  function automatic verdict_t table_step(arc_pkg::op_e op, logic [ADDR_W-1:0] a,
                                          logic [LEN_W-1:0] n);
    verdict_t v;
    logic [TOP_W-1:0] buf_end;
    v = '0;
    case (op)
      arc_pkg::OP_CLEAR: begin
        tbl_loaded = 0;
        tbl_merged = 0;
      end
      arc_pkg::OP_ADD: begin
        if (tbl_loaded >= NRANGE) begin
          v.ovf = 1'b1;
        end else begin
          tbl_base[tbl_loaded] = a;
          tbl_len[tbl_loaded] = QEND_W'(n);
          tbl_loaded++;
          tbl_merged = 0;
        end
      end
      arc_pkg::OP_BUILD: build_table();
      default: begin
        buf_end = TOP_W'(a) + TOP_W'(n);
        for (int unsigned i = 0; i < tbl_merged; i++)
          if (a >= tbl_base[i] &&
              buf_end <= TOP_W'(tbl_base[i]) + TOP_W'(tbl_len[i]))
            v.hit = 1'b1;
      end
    endcase
    v.count = COUNT_W'(tbl_loaded);
    return v;
  endfunction

  // result compare at each strobe
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_q.size() == 0) begin
        $error("result with no transaction pending");
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (inside_res_o !== want.hit) begin
          $error("inside_res expected %0d actual %0d", want.hit, inside_res_o);
          fail_count++;
        end
        if (entry_count_o !== want.count) begin
          $error("entry_count expected %0d actual %0d", want.count, entry_count_o);
          fail_count++;
        end
        if (overflow_o !== want.ovf) begin
          $error("overflow expected %0d actual %0d", want.ovf, overflow_o);
          fail_count++;
        end
      end
    end
  end

  // issue one transaction and wait for it to be taken; start stays high
  // unless an idle burst comes first
  task automatic send_txn(arc_pkg::op_e op, logic [ADDR_W-1:0] a, logic [LEN_W-1:0] n,
                          logic known, verdict_t fixed);
    verdict_t v;
    int unsigned gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    operation_i <= op;
    start_address_i <= a;
    span_length_i <= n;
    do @(posedge clk_i); while (busy_o);
    v = table_step(op, a, n);
    if (known && v !== fixed) begin
      $error("directed row disagrees with table: expected %h computed %h", fixed, v);
      fail_count++;
    end
    expected_q.push_back(v);
  endtask

  function automatic logic [ADDR_W-1:0] rand_word();
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  stim_row_t dir_rows [] = '{
    '{arc_pkg::OP_CHECK, '0, '0, 1'b1, '{1'b0, 7'd0, 1'b0}},
    '{arc_pkg::OP_BUILD, '0, '0, 1'b1, '{1'b0, 7'd0, 1'b0}},
    '{arc_pkg::OP_CHECK, '0, '0, 1'b1, '{1'b0, 7'd0, 1'b0}},
    '{arc_pkg::OP_ADD, 52'h100, 52'h100, 1'b1, '{1'b0, 7'd1, 1'b0}},
    '{arc_pkg::OP_CHECK, 52'h100, 52'h10, 1'b1, '{1'b0, 7'd1, 1'b0}},
    '{arc_pkg::OP_ADD, 52'h200, 52'h0, 1'b0, '0},
    '{arc_pkg::OP_ADD, 52'h50, 52'h10, 1'b0, '0},
    '{arc_pkg::OP_ADD, '1, '1, 1'b0, '0},
    '{arc_pkg::OP_ADD, '0, '1, 1'b0, '0},
    '{arc_pkg::OP_BUILD, '0, '0, 1'b0, '0},
    '{arc_pkg::OP_CHECK, 52'h200, 52'h0, 1'b0, '0},
    '{arc_pkg::OP_CHECK, '1, '0, 1'b0, '0},
    '{arc_pkg::OP_CHECK, '0, '1, 1'b0, '0},
    '{arc_pkg::OP_CHECK, '1, '1, 1'b0, '0},
    '{arc_pkg::OP_ADD, 52'h10, 52'h0, 1'b0, '0},
    '{arc_pkg::OP_CHECK, 52'h10, 52'h0, 1'b0, '0},
    '{arc_pkg::OP_CLEAR, '1, '1, 1'b1, '{1'b0, 7'd0, 1'b0}},
    '{arc_pkg::OP_ADD, 52'h1000, 52'h0, 1'b1, '{1'b0, 7'd1, 1'b0}},
    '{arc_pkg::OP_ADD, 52'h1000, 52'h8, 1'b1, '{1'b0, 7'd2, 1'b0}},
    '{arc_pkg::OP_BUILD, '0, '0, 1'b1, '{1'b0, 7'd1, 1'b0}},
    '{arc_pkg::OP_CHECK, 52'h1008, 52'h0, 1'b1, '{1'b1, 7'd1, 1'b0}},
    '{arc_pkg::OP_CHECK, 52'h1001, 52'h8, 1'b1, '{1'b0, 7'd1, 1'b0}}
  };

  initial begin
    arc_pkg::op_e op;
    logic [ADDR_W-1:0] a;
    logic [LEN_W-1:0] n;
    int unsigned k, drain;
    tbl_loaded = 0;
    tbl_merged = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    foreach (dir_rows[i])
      send_txn(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].len,
               dir_rows[i].known, dir_rows[i].res);

    // fill to the top and past it to hit overflow
    for (k = 0; k < NRANGE + 3; k++)
      send_txn(arc_pkg::OP_ADD, rand_word(), LEN_W'($urandom_range(0, 4096)), 1'b0, '0);
    send_txn(arc_pkg::OP_BUILD, '0, '0, 1'b0, '0);
    start_i <= 1'b0;

    // hold off until the table has answered everything
    while (expected_q.size() != 0) @(posedge clk_i);

    // random: clear, add, build and check mixed, mostly checks, on mostly clustered ranges
    k = 0;
    while (k < RAND_ITEMS) begin
      if (k > RAND_ITEMS - 60) quiet_tail = 1'b1;
      a = $urandom_range(0, 3) == 0 ? rand_word() : ADDR_W'($urandom_range(0, 65535));
      n = $urandom_range(0, 3) == 0 ? rand_word() : LEN_W'($urandom_range(0, 4096));
      case ($urandom_range(0, 19)) inside
        0: op = arc_pkg::OP_CLEAR;
        [1:6]: op = arc_pkg::OP_ADD;
        [7:8]: op = arc_pkg::OP_BUILD;
        default: op = arc_pkg::OP_CHECK;
      endcase
      send_txn(op, a, n, 1'b0, '0);
      k++;
    end
    start_i <= 1'b0;

    drain = 0;
    while (expected_q.size() != 0 && drain < 100_000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (4 * NRANGE + 10) @(posedge clk_i);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("address_range_table_checker test passed");
    end else begin
      $display("address_range_table_checker test failed");
    end
    $finish;
  end

endmodule

[address_range_table_checker.f]
sv/arc_pkg.sv
sv/arc_cell.sv
sv/address_range_table_checker.sv
sim/address_range_table_checker_tb.sv
